### src/pipr_pkg.sv
// Package: operation codes for the point-in-polygon block.
package pipr_pkg;
  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;
endpackage

### src/pipr_edge_cell.sv
// One vertex cell: holds a vertex and tests one edge against each passing query.
module pipr_edge_cell #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic signed [COORD_BITS-1:0] wx,
  input  logic signed [COORD_BITS-1:0] wy,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] ny,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  input  logic                         active,
  input  logic                         nx_hit,
  output logic signed [COORD_BITS-1:0] vx,
  output logic signed [COORD_BITS-1:0] vy,
  output logic                         hit,
  output logic                         odd
);
  localparam int DW = COORD_BITS + 1;
  logic signed [COORD_BITS-1:0] xa, ya, xb, yb;
  logic signed [DW-1:0] d1, d2, d3, d4;
  logic signed [2*DW-1:0] lhs, rhs;
  logic ge;
  logic ext;

  always_ff @(posedge clk) begin
    if (we) begin
      vx <= wx;
      vy <= wy;
    end
  end

  always_comb begin
    if (py < vy) begin
      xa = px; ya = py; xb = vx; yb = vy;
    end else begin
      xa = vx; ya = vy; xb = px; yb = py;
    end
    if (xa < qx) begin
      d1 = DW'(xb) - DW'(qx); d2 = DW'(qy) - DW'(ya);
      d3 = DW'(qx) - DW'(xa); d4 = DW'(yb) - DW'(qy);
    end else begin
      d1 = DW'(xa) - DW'(qx); d2 = DW'(yb) - DW'(qy);
      d3 = DW'(qx) - DW'(xb); d4 = DW'(qy) - DW'(ya);
    end
    lhs = d1 * d2;
    rhs = d3 * d4;
    ge  = lhs >= rhs;
    if (!active || py == vy || qy < ya || qy > yb) hit = 1'b0;
    else if (xa >= qx && xb >= qx) hit = 1'b1;
    else if (xa < qx && xb < qx) hit = 1'b0;
    else hit = ge;
    // edge into this vertex and edge out of it both counted at the vertex row
    ext = (py < vy && ny < vy) || (py > vy && ny > vy);
    odd = hit ^ (hit && nx_hit && vy == qy && !ext);
  end
endmodule

### src/point_in_polygon_ray_cast.sv
// Top level: point-in-polygon test over a row of vertex cells.
//  channel | signals                                         | dir
//  in      | in_valid in_ready operation coord_x coord_y first_vertex | in
//  out     | out_valid out_ready inside_res polygon_full      | out
// On a query, all cells test their edge at once and the parity of their hits is
// registered into the output stage.
// Reset clears the vertex count, box and overflow flag; vertex cells are
// not cleared. A stalled result holds in_ready low until it is taken.
module point_in_polygon_ray_cast #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pipr_pkg::op_t                operation,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic                         first_vertex,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         inside_res,
  output logic                         polygon_full
);
  import pipr_pkg::*;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int N  = MAX_VERTICES;

  logic [CW-1:0] count;
  logic          ovf;
  logic signed [COORD_BITS-1:0] bx0, bx1, by0, by1;
  // last stored vertex, the start of the closing edge
  logic signed [COORD_BITS-1:0] lx, ly;
  logic signed [COORD_BITS-1:0] vx [N];
  logic signed [COORD_BITS-1:0] vy [N];
  logic [N-1:0] hit, odd, we;
  logic [CW-1:0] cnt_eff;
  logic take, load, qry, in_box;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign load     = take && operation == OP_LOAD;
  assign qry      = take && operation == OP_QUERY;
  assign cnt_eff  = first_vertex ? '0 : count;
  assign in_box   = count != '0 && coord_x >= bx0 && coord_x <= bx1 &&
                    coord_y >= by0 && coord_y <= by1;

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_cell
      localparam int P = (k == 0) ? N - 1 : k - 1;
      localparam int X = (k == N - 1) ? 0 : k + 1;
      logic signed [COORD_BITS-1:0] px, py, ny;
      logic nh;
      assign we[k] = load && cnt_eff < CW'(N) && cnt_eff == CW'(k);
      always_comb begin
        if (k == 0) begin
          px = lx;
          py = ly;
        end else begin
          px = vx[P];
          py = vy[P];
        end
        // the last vertex closes the polygon back to vertex 0
        if (CW'(X) == count) begin
          ny = vy[0];
          nh = hit[0];
        end else begin
          ny = vy[X];
          nh = hit[X];
        end
      end
      pipr_edge_cell #(.COORD_BITS(COORD_BITS)) u_cell (
        .clk(clk), .we(we[k]), .wx(coord_x), .wy(coord_y),
        .px(px), .py(py), .ny(ny),
        .qx(coord_x), .qy(coord_y), .active(CW'(k) < count),
        .nx_hit(nh), .vx(vx[k]), .vy(vy[k]), .hit(hit[k]), .odd(odd[k]));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; ovf <= 1'b0; out_valid <= 1'b0;
      bx0 <= '0; bx1 <= '0; by0 <= '0; by1 <= '0;
      lx <= '0; ly <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (qry) begin
        out_valid    <= 1'b1;
        inside_res   <= in_box && ^odd;
        polygon_full <= ovf;
      end
      if (load) begin
        if (cnt_eff >= CW'(N)) begin
          ovf <= 1'b1;
        end else begin
          if (first_vertex) ovf <= 1'b0;
          count <= cnt_eff + 1'b1;
          lx <= coord_x;
          ly <= coord_y;
          if (cnt_eff == '0) begin
            bx0 <= coord_x; bx1 <= coord_x; by0 <= coord_y; by1 <= coord_y;
          end else begin
            if (coord_x < bx0) bx0 <= coord_x;
            if (coord_x > bx1) bx1 <= coord_x;
            if (coord_y < by0) by0 <= coord_y;
            if (coord_y > by1) by1 <= coord_y;
          end
        end
      end
    end
  end
endmodule

### tb/tb_point_in_polygon_ray_cast.sv
// Testbench for the ray-casting point-in-polygon block: random and directed loads and queries.
module tb_point_in_polygon_ray_cast;
  timeunit 1ns;
  timeprecision 1ps;
  import pipr_pkg::*;

  localparam int MAXV = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    op_t         op;
    logic [15:0] x;
    logic [15:0] y;
    logic        first;
  } item_t;

  typedef struct {
    logic in_poly;
    logic full;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  op_t operation = OP_LOAD;
  logic signed [15:0] coord_x = '0;
  logic signed [15:0] coord_y = '0;
  logic first_vertex = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic inside_res;
  logic polygon_full;

  point_in_polygon_ray_cast dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .coord_x(coord_x), .coord_y(coord_y),
    .first_vertex(first_vertex), .out_valid(out_valid), .out_ready(out_ready),
    .inside_res(inside_res), .polygon_full(polygon_full)
  );

  item_t    pending[$];
  verdict_t verdicts[$];
  int errors = 0;
  int queries_seen = 0;
  int loads_sent = 0;
  int idle_free = 0;
  int stall_cnt = 0;
  bit stim_done = 0;
  logic in_acc = 1'b0;

  // polygon mirror
  longint vx[MAXV];
  longint vy[MAXV];
  int vcount = 0;
  longint bx_min = 0, bx_max = 0, by_min = 0, by_max = 0;
  bit overflow = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit edge_crosses(longint qx, longint qy, longint x0, longint y0,
                                      longint x1, longint y1);
    longint xa, ya, xb, yb;
    if (y0 == y1) return 0;
    if (y0 < y1) begin xa = x0; ya = y0; xb = x1; yb = y1; end
    else begin xa = x1; ya = y1; xb = x0; yb = y0; end
    if (qy < ya || qy > yb) return 0;
    if (xa >= qx && xb >= qx) return 1;
    if (xa < qx && xb < qx) return 0;
    if (xa < qx) return (xb - qx) * (qy - ya) >= (qx - xa) * (yb - qy);
    return (xa - qx) * (yb - qy) >= (qx - xb) * (qy - ya);
  endfunction

  function automatic bit point_inside(longint qx, longint qy);
    bit hit[MAXV];
    int cnt, p, nx;
    bit ext;
    cnt = 0;
    if (vcount == 0) return 0;
    if (qx < bx_min || qx > bx_max || qy < by_min || qy > by_max) return 0;
    for (int k = 0; k < vcount; k++) begin
      p = (k == 0) ? vcount - 1 : k - 1;
      hit[k] = edge_crosses(qx, qy, vx[p], vy[p], vx[k], vy[k]);
      if (hit[k]) cnt++;
    end
    // shared vertex on the ray counts once unless it is a y extremum
    for (int k = 0; k < vcount; k++) begin
      nx = (k + 1 == vcount) ? 0 : k + 1;
      p = (k == 0) ? vcount - 1 : k - 1;
      if (hit[k] && hit[nx] && vy[k] == qy) begin
        ext = (vy[p] < vy[k] && vy[nx] < vy[k]) || (vy[p] > vy[k] && vy[nx] > vy[k]);
        if (!ext) cnt--;
      end
    end
    return cnt[0];
  endfunction

  task automatic apply_item(item_t it);
    longint x, y;
    verdict_t v;
    x = longint'($signed(it.x));
    y = longint'($signed(it.y));
    if (it.op == OP_LOAD) begin
      loads_sent++;
      if (it.first) begin vcount = 0; overflow = 0; end
      if (vcount >= MAXV) begin
        overflow = 1;
        return;
      end
      if (vcount == 0) begin
        bx_min = x; bx_max = x; by_min = y; by_max = y;
      end else begin
        if (x < bx_min) bx_min = x;
        if (x > bx_max) bx_max = x;
        if (y < by_min) by_min = y;
        if (y > by_max) by_max = y;
      end
      vx[vcount] = x;
      vy[vcount] = y;
      vcount++;
    end else begin
      v.in_poly = point_inside(x, y);
      v.full = overflow;
      verdicts.push_back(v);
    end
  endtask

  task automatic report_mismatch(string what, logic got, logic want);
    $display("mismatch on %s: got %0b want %0b at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit idle_now();
    if (idle_free > 0) return 0;
    return $urandom_range(99) < 11;
  endfunction

  // input transfer seen at the rising edge
  always @(posedge clk) in_acc <= in_valid && in_ready;

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_acc) apply_item(pending.pop_front());
      if (!in_valid || in_acc) begin
        if (pending.size() > 0 && !idle_now()) begin
          operation <= pending[0].op;
          coord_x <= pending[0].x;
          coord_y <= pending[0].y;
          first_vertex <= pending[0].first;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !idle_now();
      if (idle_free > 0) idle_free--;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        queries_seen++;
        if (verdicts.size() == 0) begin
          report_mismatch("unexpected result", out_valid, 1'b0);
        end else begin
          if (inside_res !== verdicts[0].in_poly)
            report_mismatch("inside_res", inside_res, verdicts[0].in_poly);
          if (polygon_full !== verdicts[0].full)
            report_mismatch("polygon_full", polygon_full, verdicts[0].full);
          void'(verdicts.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic item_t mk(op_t op, int x, int y, bit f);
    item_t it;
    it.op = op; it.x = x[15:0]; it.y = y[15:0]; it.first = f;
    return it;
  endfunction

  function automatic int rcoord(int span);
    if ($urandom_range(15) == 0) return $urandom_range(65535) - 32768;
    return int'($urandom_range(2 * span)) - span;
  endfunction

  initial begin
    int n, span;
    // square, extremes, vertex on ray, empty and overflow cases
    pending.push_back(mk(OP_QUERY, 0, 0, 0));
    pending.push_back(mk(OP_LOAD, -10, -10, 1));
    pending.push_back(mk(OP_LOAD, 10, -10, 0));
    pending.push_back(mk(OP_LOAD, 10, 10, 0));
    pending.push_back(mk(OP_LOAD, -10, 10, 0));
    pending.push_back(mk(OP_QUERY, 0, 0, 0));
    pending.push_back(mk(OP_QUERY, 10, 0, 0));
    pending.push_back(mk(OP_QUERY, -10, 10, 0));
    pending.push_back(mk(OP_QUERY, 11, 0, 1));
    pending.push_back(mk(OP_LOAD, 0, -32768, 1));
    pending.push_back(mk(OP_LOAD, 32767, 0, 0));
    pending.push_back(mk(OP_LOAD, 0, 32767, 0));
    pending.push_back(mk(OP_LOAD, -32768, 0, 0));
    pending.push_back(mk(OP_QUERY, 0, 0, 0));
    pending.push_back(mk(OP_QUERY, -32768, 0, 0));
    pending.push_back(mk(OP_QUERY, 32767, -32768, 0));
    pending.push_back(mk(OP_LOAD, 5, 5, 1));
    pending.push_back(mk(OP_QUERY, 5, 5, 0));
    for (int i = 0; i < MAXV + 2; i++)
      pending.push_back(mk(OP_LOAD, i, (i % 2) ? 7 : -7, i == 0));
    pending.push_back(mk(OP_QUERY, 3, 0, 0));
    while (pending.size() < 1140) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(70, 1) : $urandom_range(8, 3);
      span = ($urandom_range(1)) ? 8 : 30000;
      for (int i = 0; i < n; i++)
        pending.push_back(mk(OP_LOAD, rcoord(span), rcoord(span), i == 0));
      repeat ($urandom_range(12, 2))
        pending.push_back(mk(OP_QUERY, rcoord(span), rcoord(span), $urandom_range(1)));
    end
    stim_done = 1;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // hold a long stretch with no idling on either side
    repeat (400) @(posedge clk);
    idle_free = 300;
  end

  initial begin
    wait (stim_done && !rst);
    wait (pending.size() == 0);
    wait (verdicts.size() == 0);
    repeat (10) @(posedge clk);
    $display("covered %0d loads and %0d queries over random polygons up to overflow size",
             loads_sent, queries_seen);
    if (errors == 0 && verdicts.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

### sim.f
src/pipr_pkg.sv
src/pipr_edge_cell.sv
src/point_in_polygon_ray_cast.sv
tb/tb_point_in_polygon_ray_cast.sv
